/* rtl/core/lhp_pkg.sv */
package lhp_pkg;

  localparam int NUM_METRICS   = 9;
  localparam int NUM_BUCKETS   = 19;
  localparam int FINITE_BOUNDS = 18;

  localparam int METRIC_W = 4;
  localparam int DATA_W   = 64;
  localparam int PCT_W    = 7;

  localparam int MET_AW    = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
  localparam int BKT_IW    = $clog2(NUM_BUCKETS);
  localparam int BKT_CW    = $clog2(NUM_BUCKETS + 1);
  localparam int BKT_DEPTH = NUM_METRICS * NUM_BUCKETS;
  localparam int BKT_AW    = $clog2(BKT_DEPTH);
  localparam int DIV_W     = DATA_W + PCT_W;

  localparam int DIVISOR = 100;
  localparam int PCT_MAX = 100;

  localparam logic FUNC_OBSERVE = 1'b0;
  localparam logic FUNC_QUERY   = 1'b1;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t count;
    word_t sum;
    word_t peak;
  } stat_t;

  localparam word_t BOUND_TABLE [FINITE_BOUNDS] = '{
    64'd1, 64'd5, 64'd10, 64'd25, 64'd50, 64'd100, 64'd250, 64'd500, 64'd1000,
    64'd2500, 64'd5000, 64'd10000, 64'd25000, 64'd50000, 64'd100000,
    64'd250000, 64'd500000, 64'd1000000
  };

  function automatic word_t bucket_bound(logic [BKT_IW-1:0] b);
    word_t bound;
    bound = '1;
    if ((int'(b) < NUM_BUCKETS - 1) && (int'(b) < FINITE_BOUNDS)) begin
      bound = BOUND_TABLE[int'(b)];
    end
    return bound;
  endfunction

  // First bucket whose bound covers the value; the top bucket takes the rest
  function automatic logic [BKT_IW-1:0] pick_bucket(word_t v);
    logic [BKT_IW-1:0] idx;
    idx = BKT_IW'(NUM_BUCKETS - 1);
    for (int b = NUM_BUCKETS - 2; b >= 0; b--) begin
      if (bucket_bound(BKT_IW'(b)) >= v) begin
        idx = BKT_IW'(b);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/core/lhp_ram.sv */
module lhp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* rtl/core/lhp_div100.sv */
module lhp_div100 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lhp_pkg::DIV_W-1:0] dividend_i,
  output logic                      done_o,
  output lhp_pkg::word_t            quot_o,
  output logic                      rem_nz_o
);
  import lhp_pkg::*;

  localparam int          REM_W    = $clog2(DIVISOR);
  localparam int          LIMB_W   = 24;
  localparam int          LIMBS    = 3;
  localparam int          PAD_W    = LIMB_W * LIMBS;
  localparam int          PART_W   = REM_W + LIMB_W;
  localparam int          CNT_W    = $clog2(LIMBS + 1);
  localparam int          RECIP_SH = 37;
  localparam logic [31:0] RECIP    = 32'h51EB_851F;
  localparam int          PROD_W   = PART_W + 32;

  logic [PAD_W-1:0]  dq_q;
  logic [REM_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [PART_W-1:0] part;
  logic [PROD_W-1:0] prod;
  logic [LIMB_W-1:0] q_limb;
  logic [PART_W-1:0] part_rem;

  // one 24-bit slice per cycle, headed by the remainder so far; quotient
  // slices shift into dq_q
  assign part     = {rem_q, dq_q[PAD_W-1 -: LIMB_W]};
  // floor(part / 100) by reciprocal multiply, exact for any part below 2^32
  assign prod     = PROD_W'(part) * PROD_W'(RECIP);
  assign q_limb   = prod[RECIP_SH +: LIMB_W];
  assign part_rem = part - PART_W'(q_limb) * PART_W'(DIVISOR);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= PAD_W'(dividend_i);
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[PAD_W-LIMB_W-1:0], q_limb};
      rem_q <= part_rem[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(LIMBS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign quot_o   = dq_q[DATA_W-1:0];
  assign rem_nz_o = rem_q != '0;

endmodule

/* rtl/core/latency_histogram_percentile.sv */
// Observe: accept, then one read-modify-write of the statistics memory and the
//   bucket memory.
// Query: statistics read, divide by 100, then a walk of k buckets (1..19) with one
//   bucket memory read per cycle; the result is registered when the walk ends.
//   A stalled result holds the input off.
// Empty metric, bad percentile or bad metric: no divide or walk; result registered from the statistics read.
// Reset (asynchronous): clears control and per-entry valid bits; all stores read zero.
module latency_histogram_percentile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [lhp_pkg::METRIC_W-1:0] metric_i,
  input  lhp_pkg::word_t               value_i,
  input  logic [lhp_pkg::PCT_W-1:0]    percentile_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output lhp_pkg::word_t               sample_count_o,
  output lhp_pkg::word_t               sum_us_o,
  output lhp_pkg::word_t               max_us_o,
  output lhp_pkg::word_t               percentile_us_o
);
  import lhp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_OBS   = 3'd1;
  localparam logic [2:0] ST_QSTAT = 3'd2;
  localparam logic [2:0] ST_QDIV  = 3'd3;
  localparam logic [2:0] ST_QWALK = 3'd4;
  localparam logic [2:0] ST_QDONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              accept;
  logic              met_ok;
  logic [MET_AW-1:0] met_idx;
  logic [BKT_AW-1:0] base_in;
  logic [BKT_IW-1:0] obs_bkt;

  logic [MET_AW-1:0] met_q;
  logic              met_ok_q;
  word_t             value_q;
  logic [PCT_W-1:0]  pct_q;
  logic [BKT_AW-1:0] base_q;
  logic [BKT_AW-1:0] obs_addr_q;

  stat_t             stat_rd, stat_wr;
  logic              stat_rd_en;
  word_t             bkt_rd;
  logic              bkt_rd_en;
  logic [BKT_AW-1:0] bkt_rd_addr;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  word_t             div_quot;
  logic              div_rem_nz;
  word_t             target_q;

  logic [BKT_CW-1:0] rd_idx_q;
  logic              chk_q;
  logic [BKT_IW-1:0] chk_idx_q;
  word_t             run_q;
  word_t             run_sum;
  logic              walk_issue;
  logic              walk_hit;
  logic              pct_ok;

  word_t             res_cnt_q, res_sum_q, res_max_q, res_pct_q;
  logic              out_valid_q;
  logic              out_load;
  word_t             out_cnt_q, out_sum_q, out_max_q, out_pct_q;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign met_ok     = 32'(metric_i) < 32'(NUM_METRICS);
  assign met_idx    = MET_AW'(metric_i);
  assign base_in    = BKT_AW'(32'(met_idx) * NUM_BUCKETS);
  assign obs_bkt    = pick_bucket(value_i);

  assign stat_rd_en = accept && met_ok;
  assign stat_wr.count = stat_rd.count + 1'b1;
  assign stat_wr.sum   = stat_rd.sum + value_q;
  assign stat_wr.peak  = (value_q > stat_rd.peak) ? value_q : stat_rd.peak;

  lhp_ram #(
    .DEPTH (NUM_METRICS),
    .WIDTH ($bits(stat_t))
  ) u_stat_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (stat_rd_en),
    .rd_addr_i (met_idx),
    .rd_data_o (stat_rd),
    .wr_en_i   (state_q == ST_OBS),
    .wr_addr_i (met_q),
    .wr_data_i (stat_wr)
  );

  assign walk_issue  = (state_q == ST_QWALK) && (rd_idx_q < BKT_CW'(NUM_BUCKETS));
  assign bkt_rd_en   = (accept && met_ok && func_i == FUNC_OBSERVE) || walk_issue;
  assign bkt_rd_addr = walk_issue ? base_q + BKT_AW'(rd_idx_q[BKT_IW-1:0])
                                  : base_in + BKT_AW'(obs_bkt);

  lhp_ram #(
    .DEPTH (BKT_DEPTH),
    .WIDTH (DATA_W)
  ) u_bkt_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (bkt_rd_en),
    .rd_addr_i (bkt_rd_addr),
    .rd_data_o (bkt_rd),
    .wr_en_i   (state_q == ST_OBS),
    .wr_addr_i (obs_addr_q),
    .wr_data_i (bkt_rd + 1'b1)
  );

  // target = ceil(count * p / 100); never below one for a non-empty metric
  assign pct_ok       = (pct_q != '0) && (pct_q <= PCT_W'(PCT_MAX));
  assign div_start    = (state_q == ST_QSTAT) && met_ok_q && (stat_rd.count != '0) && pct_ok;
  assign div_dividend = DIV_W'(stat_rd.count) * DIV_W'(pct_q);

  lhp_div100 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  assign run_sum  = run_q + bkt_rd;
  assign walk_hit = chk_q && ((run_sum >= target_q) ||
                              (chk_idx_q == BKT_IW'(NUM_BUCKETS - 1)));
  assign out_load = (state_q == ST_QDONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_QUERY) begin
            state_d = ST_QSTAT;
          end else if (met_ok) begin
            state_d = ST_OBS;
          end
        end
      end
      ST_OBS:   state_d = ST_IDLE;
      ST_QSTAT: state_d = div_start ? ST_QDIV : ST_QDONE;
      ST_QDIV: begin
        if (div_done) begin
          state_d = ST_QWALK;
        end
      end
      ST_QWALK: begin
        if (walk_hit) begin
          state_d = ST_QDONE;
        end
      end
      ST_QDONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chk_q       <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_QDIV) begin
        chk_q    <= 1'b0;
        rd_idx_q <= '0;
      end else begin
        chk_q <= walk_issue;
        if (walk_issue) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      met_q      <= met_idx;
      met_ok_q   <= met_ok;
      value_q    <= value_i;
      pct_q      <= percentile_i;
      base_q     <= base_in;
      obs_addr_q <= base_in + BKT_AW'(obs_bkt);
    end
    if (state_q == ST_QSTAT) begin
      res_cnt_q <= met_ok_q ? stat_rd.count : '0;
      res_sum_q <= met_ok_q ? stat_rd.sum : '0;
      res_max_q <= met_ok_q ? stat_rd.peak : '0;
      res_pct_q <= '0;
    end
    if (div_done) begin
      target_q <= div_quot + word_t'(div_rem_nz);
    end
    if (state_q == ST_QDIV) begin
      run_q <= '0;
    end else if (chk_q) begin
      run_q <= run_sum;
    end
    chk_idx_q <= rd_idx_q[BKT_IW-1:0];
    // the top bucket's bound is all ones, so a miss and a hit there agree
    if (state_q == ST_QWALK && walk_hit) begin
      res_pct_q <= bucket_bound(chk_idx_q);
    end
    if (out_load) begin
      out_cnt_q <= res_cnt_q;
      out_sum_q <= res_sum_q;
      out_max_q <= res_max_q;
      out_pct_q <= res_pct_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_count_o  = out_cnt_q;
  assign sum_us_o        = out_sum_q;
  assign max_us_o        = out_max_q;
  assign percentile_us_o = out_pct_q;

endmodule

/* rtl/core/lhp_checker.sv */
module lhp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         func_i,
  input logic [lhp_pkg::METRIC_W-1:0] metric_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input lhp_pkg::word_t               sample_count_o,
  input lhp_pkg::word_t               percentile_us_o
);
  import lhp_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_count_o)
      && $stable(percentile_us_o))
    else $error("stalled result changed");

  // a valid observation occupies the block for its write-back cycle
  a_obs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && func_i == FUNC_OBSERVE && 32'(metric_i) < 32'(NUM_METRICS)
      |=> in_stall_o)
    else $error("observation write-back skipped");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && func_i == FUNC_QUERY |=> in_stall_o)
    else $error("query not held");

  // an empty metric never reports a percentile bound
  a_empty_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_count_o == '0 |-> percentile_us_o == '0)
    else $error("percentile bound on empty metric");

endmodule

bind latency_histogram_percentile lhp_checker u_lhp_checker (.*);
